FILE: sv/pfn_pkg.sv
`timescale 1ns / 1ps
package pfn_pkg;

  localparam int PFN_COORD_WIDTH = 24;
  localparam int PFN_FRAC_BITS   = 14;
  localparam int OUT_W           = 16;
  localparam int EDGE_W          = 31;
  localparam int CROSS_W         = 32;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic MODE_TRI  = 1'b0;
  localparam logic MODE_QUAD = 1'b1;

  function automatic int edge_width(input int cw);
    return (cw + 1 > EDGE_W) ? EDGE_W : cw + 1;
  endfunction

endpackage

FILE: sv/pfn_front.sv
`timescale 1ns / 1ps
module pfn_front #(
  parameter int CW = pfn_pkg::PFN_COORD_WIDTH
) (
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [12*CW-1:0]                             in_v,
  input  logic                                         mode,
  input  logic                                         q_full,
  output logic                                         q_push,
  output logic [12*pfn_pkg::edge_width(CW)+1-1:0]      q_data
);
  import pfn_pkg::*;

  localparam int EW = edge_width(CW);
  localparam int XS = (CW + 1 > EDGE_W) ? CW + 1 - EDGE_W : 0;
  localparam logic signed [63:0] EDGE_MAX = 64'sd1073741823;
  localparam logic signed [63:0] EDGE_MIN = -64'sd1073741824;

  logic signed [63:0] cv [12];
  logic signed [63:0] e64 [2][6];
  logic signed [63:0] es  [2][6];
  logic [1:0]         sel [2];
  logic               fit;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      cv[i] = $signed(in_v[i*CW +: CW]);
    end
    for (int k = 0; k < 3; k++) begin
      e64[0][k]   = cv[3+k] - cv[k];
      e64[0][3+k] = (mode == MODE_QUAD) ? (cv[9+k] - cv[k]) : (cv[6+k] - cv[k]);
      e64[1][k]   = cv[6+k] - cv[3+k];
      e64[1][3+k] = cv[9+k] - cv[3+k];
    end
    for (int t = 0; t < 2; t++) begin
      sel[t] = 2'(XS);
      for (int s = XS; s >= 0; s--) begin
        fit = 1'b1;
        for (int i = 0; i < 6; i++) begin
          if (((e64[t][i] >>> s) > EDGE_MAX) || ((e64[t][i] >>> s) < EDGE_MIN)) begin
            fit = 1'b0;
          end
        end
        if (fit) begin
          sel[t] = 2'(s);
        end
      end
      for (int i = 0; i < 6; i++) begin
        es[t][i] = e64[t][i] >>> sel[t];
      end
    end
    q_data[12*EW] = mode;
    for (int i = 0; i < 6; i++) begin
      q_data[6*EW + i*EW +: EW] = es[0][i][EW-1:0];
      q_data[i*EW +: EW]        = es[1][i][EW-1:0];
    end
  end

endmodule

FILE: sv/pfn_fifo.sv
`timescale 1ns / 1ps
module pfn_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = pfn_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         rvalid,
  output logic [W-1:0] rdata
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   mem_r [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           do_pop;

  assign full   = (cnt_r == CNW'(DEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = mem_r[rp_r];
  assign do_pop = pop && rvalid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: sv/pfn_unit3.sv
`timescale 1ns / 1ps
module pfn_unit3 #(
  parameter int IW  = 32,
  parameter int F   = pfn_pkg::PFN_FRAC_BITS,
  parameter int SBW = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [3*IW-1:0]       in_c,
  input  logic [SBW-1:0]        in_sb,
  output logic                  out_vld,
  output logic [3*(F+2)-1:0]    out_n,
  output logic                  out_deg,
  output logic [SBW-1:0]        out_sb
);
  localparam int MW = IW - 1;
  localparam int SW = 2*MW + 2;
  localparam int RW = MW + 1;
  localparam int QW = F + 1;
  localparam int NW = MW + F + 1;
  localparam int OW = QW + 1;

  logic signed [IW-1:0] ci;
  logic [MW-1:0]   a_nxt [3], a_r [3], ab_r [3];
  logic [2:0]      sg_r, sgb_r;
  logic [SBW-1:0]  sba_r, sbb_r;
  logic            va_r, vb_r;
  logic [2*MW-1:0] sq_r [3];

  logic [SW-1:0]   sum_r  [0:RW];
  logic [RW+1:0]   rem_r  [0:RW];
  logic [RW-1:0]   root_r [0:RW];
  logic [3*MW-1:0] ap_r   [0:RW];
  logic [2:0]      sgs_r  [0:RW];
  logic [SBW-1:0]  sbs_r  [0:RW];
  logic [RW:0]     vs_r;
  logic [RW+1:0]   rem_nxt  [1:RW];
  logic [RW-1:0]   root_nxt [1:RW];
  logic [RW+1:0]   cat, trial;

  logic [3*NW-1:0] num_r  [0:QW];
  logic [3*RW-1:0] remd_r [0:QW];
  logic [3*QW-1:0] q_r    [0:QW];
  logic [RW-1:0]   len_r  [0:QW];
  logic [2:0]      sgd_r  [0:QW];
  logic [SBW-1:0]  sbd_r  [0:QW];
  logic [QW:0]     vd_r;
  logic [3*NW-1:0] num0;
  logic [3*RW-1:0] remd0;
  logic [NW-1:0]   nv;
  logic [3*RW-1:0] remd_nxt [1:QW];
  logic [3*QW-1:0] q_nxt    [1:QW];
  logic [RW:0]     dt;
  logic            ge;
  logic            gd;

  logic [OW-1:0]   qe;
  logic [3*OW-1:0] n_nxt, n_r;
  logic            deg_r, vo_r;
  logic [SBW-1:0]  sbo_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ci       = $signed(in_c[i*IW +: IW]);
      a_nxt[i] = ci[IW-1] ? MW'(-ci) : ci[MW-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < RW; k++) begin
      cat         = {rem_r[k][RW-1:0], sum_r[k][SW-1-2*k -: 2]};
      trial       = {root_r[k], 2'b01};
      ge          = (cat >= trial);
      rem_nxt[k+1]  = ge ? cat - trial : cat;
      root_nxt[k+1] = {root_r[k][RW-2:0], ge};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv = (NW'(ap_r[RW][i*MW +: MW]) << F) + NW'(root_r[RW] >> 1);
      num0[i*NW +: NW]  = nv;
      remd0[i*RW +: RW] = RW'(nv >> QW);
    end
    for (int j = 0; j < QW; j++) begin
      for (int i = 0; i < 3; i++) begin
        dt = {remd_r[j][i*RW +: RW], num_r[j][i*NW + QW - 1 - j]};
        gd = (dt >= {1'b0, len_r[j]});
        remd_nxt[j+1][i*RW +: RW] = gd ? RW'(dt - {1'b0, len_r[j]}) : dt[RW-1:0];
        q_nxt[j+1][i*QW +: QW]    = {q_r[j][i*QW +: QW-1], gd};
      end
    end
    for (int i = 0; i < 3; i++) begin
      qe = {1'b0, q_r[QW][i*QW +: QW]};
      if (len_r[QW] == '0) begin
        n_nxt[i*OW +: OW] = '0;
      end else begin
        n_nxt[i*OW +: OW] = sgd_r[QW][i] ? -qe : qe;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vs_r <= '0;
      vd_r <= '0;
      vo_r <= 1'b0;
    end else if (en) begin
      va_r <= in_vld;
      vb_r <= va_r;
      vs_r <= {vs_r[RW-1:0], vb_r};
      vd_r <= {vd_r[QW-1:0], vs_r[RW]};
      vo_r <= vd_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_r[i]  <= a_nxt[i];
        sg_r[i] <= in_c[i*IW + IW - 1];
        ab_r[i] <= a_r[i];
        sq_r[i] <= a_r[i] * a_r[i];
      end
      sba_r <= in_sb;
      sgb_r <= sg_r;
      sbb_r <= sba_r;

      sum_r[0]  <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      ap_r[0]   <= {ab_r[2], ab_r[1], ab_r[0]};
      sgs_r[0]  <= sgb_r;
      sbs_r[0]  <= sbb_r;
      for (int k = 1; k <= RW; k++) begin
        sum_r[k]  <= sum_r[k-1];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        ap_r[k]   <= ap_r[k-1];
        sgs_r[k]  <= sgs_r[k-1];
        sbs_r[k]  <= sbs_r[k-1];
      end

      num_r[0]  <= num0;
      remd_r[0] <= remd0;
      q_r[0]    <= '0;
      len_r[0]  <= root_r[RW];
      sgd_r[0]  <= sgs_r[RW];
      sbd_r[0]  <= sbs_r[RW];
      for (int j = 1; j <= QW; j++) begin
        num_r[j]  <= num_r[j-1];
        remd_r[j] <= remd_nxt[j];
        q_r[j]    <= q_nxt[j];
        len_r[j]  <= len_r[j-1];
        sgd_r[j]  <= sgd_r[j-1];
        sbd_r[j]  <= sbd_r[j-1];
      end

      n_r   <= n_nxt;
      deg_r <= (len_r[QW] == '0);
      sbo_r <= sbd_r[QW];
    end
  end

  assign out_vld = vo_r;
  assign out_n   = n_r;
  assign out_deg = deg_r;
  assign out_sb  = sbo_r;

endmodule

FILE: sv/pfn_tri.sv
`timescale 1ns / 1ps
module pfn_tri #(
  parameter int EW  = pfn_pkg::EDGE_W,
  parameter int F   = pfn_pkg::PFN_FRAC_BITS,
  parameter int SBW = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [6*EW-1:0]    in_d,
  input  logic [SBW-1:0]     in_sb,
  output logic               out_vld,
  output logic [3*(F+2)-1:0] out_n,
  output logic               out_deg,
  output logic [SBW-1:0]     out_sb
);
  import pfn_pkg::*;

  localparam int PW  = 2*EW;
  localparam int XW  = 2*EW + 1;
  localparam int SAW = $clog2(XW + 1);
  localparam logic signed [63:0] CROSS_MINV = -64'sd2147483648;

  logic signed [EW-1:0]      d [6];
  logic signed [PW-1:0]      p_nxt [6], p_r [6];
  logic signed [XW-1:0]      x_nxt [3], xa_r [3], xb_r [3], xc_r [3];
  logic [XW-1:0]             or_nxt, or_r;
  logic [SAW-1:0]            blen, sa_nxt, sa_r;
  logic signed [63:0]        xw [3], sh [3], sh1 [3];
  logic                      big;
  logic signed [CROSS_W-1:0] c_nxt [3], c_r [3];
  logic [4:0]                vld_r;
  logic [SBW-1:0]            sb_r [5];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      d[i] = $signed(in_d[i*EW +: EW]);
    end
    p_nxt[0] = d[1] * d[5];
    p_nxt[1] = d[2] * d[4];
    p_nxt[2] = d[2] * d[3];
    p_nxt[3] = d[0] * d[5];
    p_nxt[4] = d[0] * d[4];
    p_nxt[5] = d[1] * d[3];
    for (int i = 0; i < 3; i++) begin
      x_nxt[i] = XW'(p_r[2*i]) - XW'(p_r[2*i+1]);
    end
    or_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      or_nxt = or_nxt | (xa_r[i] ^ {XW{xa_r[i][XW-1]}});
    end
    blen = '0;
    for (int i = 0; i < XW; i++) begin
      if (or_r[i]) begin
        blen = SAW'(i + 1);
      end
    end
    sa_nxt = (blen > SAW'(CROSS_W - 1)) ? SAW'(blen - SAW'(CROSS_W - 1)) : '0;
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      xw[i]  = xc_r[i];
      sh[i]  = xw[i] >>> sa_r;
      sh1[i] = sh[i] >>> 1;
      if (sh[i] == CROSS_MINV) begin
        big = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      c_nxt[i] = big ? sh1[i][CROSS_W-1:0] : sh[i][CROSS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= p_nxt;
      xa_r   <= x_nxt;
      xb_r   <= xa_r;
      or_r   <= or_nxt;
      xc_r   <= xb_r;
      sa_r   <= sa_nxt;
      c_r    <= c_nxt;
      sb_r[0] <= in_sb;
      for (int k = 1; k < 5; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  pfn_unit3 #(
    .IW  (CROSS_W),
    .F   (F),
    .SBW (SBW)
  ) u_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld_r[4]),
    .in_c    ({c_r[2], c_r[1], c_r[0]}),
    .in_sb   (sb_r[4]),
    .out_vld (out_vld),
    .out_n   (out_n),
    .out_deg (out_deg),
    .out_sb  (out_sb)
  );

endmodule

FILE: sv/pfn_back.sv
`timescale 1ns / 1ps
module pfn_back #(
  parameter int CW = pfn_pkg::PFN_COORD_WIDTH,
  parameter int F  = pfn_pkg::PFN_FRAC_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    q_vld,
  input  logic [12*pfn_pkg::edge_width(CW)+1-1:0] q_data,
  output logic                                    q_pop,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [pfn_pkg::OUT_W-1:0]               out_nx,
  output logic [pfn_pkg::OUT_W-1:0]               out_ny,
  output logic [pfn_pkg::OUT_W-1:0]               out_nz,
  output logic                                    out_deg
);
  import pfn_pkg::*;

  localparam int EW  = edge_width(CW);
  localparam int OW  = F + 2;
  localparam int SW2 = 3 + 3*OW;

  logic              en;
  logic              va, vb, vf;
  logic [3*OW-1:0]   na, nb, nf;
  logic              dga, dgb, dgf;
  logic              mode_a;
  logic [3*(OW+1)-1:0] sum;
  logic [SW2-1:0]    sbf;
  logic              f_mode, f_pre, f_dga;
  logic [3*OW-1:0]   f_na;
  logic [3*OW-1:0]   nsel;
  logic              dsel;
  logic signed [31:0] w;
  logic [OUT_W-1:0]  sat [3];
  logic              vo_r;
  logic [OUT_W-1:0]  nx_r, ny_r, nz_r;
  logic              deg_r;

  assign en    = !vo_r || out_ready;
  assign q_pop = en;

  pfn_tri #(.EW(EW), .F(F), .SBW(1)) u_tri_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (q_vld),
    .in_d    (q_data[6*EW +: 6*EW]),
    .in_sb   (q_data[12*EW]),
    .out_vld (va),
    .out_n   (na),
    .out_deg (dga),
    .out_sb  (mode_a)
  );

  pfn_tri #(.EW(EW), .F(F), .SBW(1)) u_tri_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (q_vld),
    .in_d    (q_data[0 +: 6*EW]),
    .in_sb   (q_data[12*EW]),
    .out_vld (vb),
    .out_n   (nb),
    .out_deg (dgb),
    .out_sb  ()
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i*(OW+1) +: OW+1] = (OW+1)'($signed(na[i*OW +: OW]))
                            + (OW+1)'($signed(nb[i*OW +: OW]));
    end
  end

  pfn_unit3 #(.IW(OW + 1), .F(F), .SBW(SW2)) u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (va && vb),
    .in_c    (sum),
    .in_sb   ({mode_a, dga || dgb, dga, na}),
    .out_vld (vf),
    .out_n   (nf),
    .out_deg (dgf),
    .out_sb  (sbf)
  );

  assign {f_mode, f_pre, f_dga, f_na} = sbf;

  always_comb begin
    if (f_mode == MODE_TRI) begin
      dsel = f_dga;
      nsel = f_na;
    end else begin
      dsel = f_pre || dgf;
      nsel = nf;
    end
    for (int i = 0; i < 3; i++) begin
      w = 32'($signed(nsel[i*OW +: OW]));
      if (dsel) begin
        sat[i] = '0;
      end else if (w > 32'sd32767) begin
        sat[i] = 16'h7fff;
      end else if (w < -32'sd32768) begin
        sat[i] = 16'h8000;
      end else begin
        sat[i] = w[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vf) begin
      nx_r  <= sat[0];
      ny_r  <= sat[1];
      nz_r  <= sat[2];
      deg_r <= dsel;
    end
  end

  assign out_valid = vo_r;
  assign out_nx    = nx_r;
  assign out_ny    = ny_r;
  assign out_nz    = nz_r;
  assign out_deg   = deg_r;

endmodule

FILE: sv/polygon_face_normal.sv
`timescale 1ns / 1ps
// Pipeline depth at the default widths comes mostly from the two chained normalize units
//   (isqrt 33 then 18 deep, divide 16 deep in each).
// Throughput: one polygon per cycle; every stage advances together unless the
//   output register holds an untaken result, while a 4-entry queue keeps accepting until full.
// Reset: synchronous active-low; clears valid state and sets the mode register mode_r to quad.
module polygon_face_normal #(
  parameter int COORD_WIDTH      = pfn_pkg::PFN_COORD_WIDTH,
  parameter int NORMAL_FRAC_BITS = pfn_pkg::PFN_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [COORD_WIDTH-1:0]       in_v0_x,
  input  logic [COORD_WIDTH-1:0]       in_v0_y,
  input  logic [COORD_WIDTH-1:0]       in_v0_z,
  input  logic [COORD_WIDTH-1:0]       in_v1_x,
  input  logic [COORD_WIDTH-1:0]       in_v1_y,
  input  logic [COORD_WIDTH-1:0]       in_v1_z,
  input  logic [COORD_WIDTH-1:0]       in_v2_x,
  input  logic [COORD_WIDTH-1:0]       in_v2_y,
  input  logic [COORD_WIDTH-1:0]       in_v2_z,
  input  logic [COORD_WIDTH-1:0]       in_v3_x,
  input  logic [COORD_WIDTH-1:0]       in_v3_y,
  input  logic [COORD_WIDTH-1:0]       in_v3_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pfn_pkg::OUT_W-1:0]    out_normal_x,
  output logic [pfn_pkg::OUT_W-1:0]    out_normal_y,
  output logic [pfn_pkg::OUT_W-1:0]    out_normal_z,
  output logic                         out_degenerate,
  input  logic                         cfg_we,
  input  logic                         cfg_wdata
);
  import pfn_pkg::*;

  localparam int EW = edge_width(COORD_WIDTH);
  localparam int QW = 12*EW + 1;

  logic          mode_r;
  logic          q_full, q_push, q_vld, q_pop;
  logic [QW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_QUAD;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  pfn_front #(.CW(COORD_WIDTH)) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_v     ({in_v3_z, in_v3_y, in_v3_x, in_v2_z, in_v2_y, in_v2_x,
                in_v1_z, in_v1_y, in_v1_x, in_v0_z, in_v0_y, in_v0_x}),
    .mode     (mode_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  pfn_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_vld),
    .rdata  (q_rdata)
  );

  pfn_back #(.CW(COORD_WIDTH), .F(NORMAL_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_nx    (out_normal_x),
    .out_ny    (out_normal_y),
    .out_nz    (out_normal_z),
    .out_deg   (out_degenerate)
  );

endmodule
